/* rtl/kitc_pkg.sv */
// Shared types, field widths and codes for the kth-item count tree.
package kitc_pkg;

  localparam int KINDS_DEFAULT = 65536;
  localparam int CNT_W         = 40;
  localparam int KIND_W        = 16;
  localparam int AMT_W         = 32;
  localparam int STATUS_W      = 2;

  localparam logic OP_TAKE = 1'b0;
  localparam logic OP_ADD  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NEG   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OVF   = 2'd3;

  typedef struct packed {
    logic                    opcode;
    logic [CNT_W-1:0]        rank;
    logic [KIND_W-1:0]       kind_index;
    logic signed [AMT_W-1:0] amount;
  } item_t;

  typedef struct packed {
    logic [KIND_W-1:0]   found_kind;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

/* rtl/kitc_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module kitc_ram #(
  parameter int WIDTH = kitc_pkg::CNT_W,
  parameter int DEPTH = 2 * kitc_pkg::KINDS_DEFAULT,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/kitc_engine.sv */
// Tree sequencer: clearing sweep, rank descent and count update over the tree RAM.
module kitc_engine #(
  parameter int KINDS = kitc_pkg::KINDS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  kitc_pkg::item_t   req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output kitc_pkg::result_t rsp
);

  localparam int LEVELS = $clog2(KINDS);
  localparam int ADDR_W = LEVELS + 1;
  localparam int DEPTH  = 2 ** ADDR_W;
  localparam int CW     = kitc_pkg::CNT_W;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_DOWN  = 7'b0000100,
    S_TLEAF = 7'b0001000,
    S_ACHK  = 7'b0010000,
    S_AUP   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t                          state, state_next;
  logic [ADDR_W-1:0]               node, node_next;
  logic [CW-1:0]                   node_val, node_val_next;
  logic [CW-1:0]                   rank_r, rank_r_next;
  logic [CW-1:0]                   total, total_next;
  logic [CW-1:0]                   delta, delta_next;
  logic [kitc_pkg::STATUS_W-1:0]   status, status_next;
  logic [kitc_pkg::KIND_W-1:0]     found, found_next;

  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [CW-1:0]     wdata, rdata;

  logic              go_left;
  logic [ADDR_W-1:0] child, parent;
  logic [CW-1:0]     right_val, rank_right;
  logic [CW+1:0]     delta_ext, nc, nt;
  logic              rank_bad, kind_bad;

  kitc_ram #(
    .WIDTH (CW),
    .DEPTH (DEPTH)
  ) u_tree_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign go_left    = (rdata >= rank_r);
  assign child      = {node[ADDR_W-2:0], ~go_left};
  assign parent     = node >> 1;
  assign right_val  = node_val - rdata;
  assign rank_right = rank_r - rdata;
  assign delta_ext  = {{2{delta[CW-1]}}, delta};
  assign nc         = {2'b00, rdata} + delta_ext;
  assign nt         = {2'b00, total} + delta_ext;
  assign rank_bad   = (req.rank == '0) || (req.rank > total);
  assign kind_bad   = ({16'b0, req.kind_index} >= 32'(KINDS));

  assign req_ready       = (state == S_IDLE);
  assign rsp_valid       = (state == S_DONE);
  assign rsp.found_kind  = found;
  assign rsp.status      = status;

  always_comb begin
    state_next    = state;
    node_next     = node;
    node_val_next = node_val;
    rank_r_next   = rank_r;
    total_next    = total;
    delta_next    = delta;
    status_next   = status;
    found_next    = found;
    we            = 1'b0;
    waddr         = node;
    wdata         = '0;
    re            = 1'b0;
    raddr         = node;
    unique case (state)
      S_CLEAR: begin
        we        = 1'b1;
        node_next = node + ADDR_W'(1);
        if (node == '1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          found_next  = '0;
          status_next = kitc_pkg::ST_OK;
          if (req.opcode == kitc_pkg::OP_TAKE) begin
            if (rank_bad) begin
              status_next = kitc_pkg::ST_RANGE;
              state_next  = S_DONE;
            end else begin
              re            = 1'b1;
              raddr         = ADDR_W'(2);
              node_next     = ADDR_W'(1);
              node_val_next = total;
              rank_r_next   = req.rank;
              total_next    = total - CW'(1);
              state_next    = S_DOWN;
            end
          end else begin
            if (kind_bad) begin
              status_next = kitc_pkg::ST_RANGE;
              state_next  = S_DONE;
            end else begin
              re         = 1'b1;
              raddr      = {1'b1, LEVELS'(req.kind_index)};
              node_next  = {1'b1, LEVELS'(req.kind_index)};
              delta_next = {{(CW - kitc_pkg::AMT_W){req.amount[kitc_pkg::AMT_W-1]}},
                            req.amount};
              state_next = S_ACHK;
            end
          end
        end
      end
      S_DOWN: begin
        we            = 1'b1;
        wdata         = node_val - CW'(1);
        node_next     = child;
        node_val_next = go_left ? rdata : right_val;
        rank_r_next   = go_left ? rank_r : rank_right;
        if (child[ADDR_W-1]) begin
          state_next = S_TLEAF;
        end else begin
          re    = 1'b1;
          raddr = {child[ADDR_W-2:0], 1'b0};
        end
      end
      S_TLEAF: begin
        we         = 1'b1;
        wdata      = node_val - CW'(1);
        found_next = kitc_pkg::KIND_W'(node[LEVELS-1:0]);
        state_next = S_DONE;
      end
      S_ACHK: begin
        if (nc[CW+1]) begin
          status_next = kitc_pkg::ST_NEG;
          state_next  = S_DONE;
        end else if (nt[CW+1:CW] == 2'b01) begin
          status_next = kitc_pkg::ST_OVF;
          state_next  = S_DONE;
        end else begin
          total_next = nt[CW-1:0];
          we         = 1'b1;
          wdata      = nc[CW-1:0];
          node_next  = parent;
          if (parent == ADDR_W'(1)) begin
            state_next = S_DONE;
          end else begin
            re         = 1'b1;
            raddr      = parent;
            state_next = S_AUP;
          end
        end
      end
      S_AUP: begin
        we        = 1'b1;
        wdata     = rdata + delta;
        node_next = parent;
        if (parent == ADDR_W'(1)) begin
          state_next = S_DONE;
        end else begin
          re    = 1'b1;
          raddr = parent;
        end
      end
      S_DONE: begin
        if (rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
        node_next  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      node  <= '0;
      total <= '0;
    end else begin
      state <= state_next;
      node  <= node_next;
      total <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    node_val <= node_val_next;
    rank_r   <= rank_r_next;
    delta    <= delta_next;
    status   <= status_next;
    found    <= found_next;
  end

endmodule

/* rtl/kth_item_count_tree_unit.sv */
// Top level of the kth-item count tree: tree sequencer and result register.
// A take walks down and an add walks up the tree (LEVELS = clog2(KINDS), 16 by default), with
// one tree RAM access per level; an out-of-range item skips the walk, a rejected add stops at the leaf.
// Throughput: one transaction at a time, the next accepted the cycle after the result register loads.
// Reset runs a clearing sweep over every tree RAM word, with item_ready low meanwhile.
module kth_item_count_tree_unit #(
  parameter int KINDS = kitc_pkg::KINDS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  kitc_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output kitc_pkg::result_t result
);

  logic              eng_rsp_valid;
  logic              eng_rsp_ready;
  kitc_pkg::result_t eng_rsp;

  kitc_engine #(
    .KINDS (KINDS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .req_valid (item_valid),
    .req_ready (item_ready),
    .req       (item),
    .rsp_valid (eng_rsp_valid),
    .rsp_ready (eng_rsp_ready),
    .rsp       (eng_rsp)
  );

  assign eng_rsp_ready = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (eng_rsp_valid && eng_rsp_ready) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_rsp_valid && eng_rsp_ready) begin
      result <= eng_rsp;
    end
  end

endmodule

/* rtl/kitc_checker.sv */
// Port-level assertions for the kth-item count tree, bound to the top level.
module kitc_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input kitc_pkg::item_t   item,
  input logic              result_valid,
  input logic              result_ready,
  input kitc_pkg::result_t result
);

  a_reset_blocks_input: assert property (@(posedge clk)
    rst |=> !item_ready && !result_valid)
    else $error("item_ready or result_valid high after reset");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("second transaction accepted while one is in the tree");

  a_failed_has_no_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.status == kitc_pkg::ST_OK) || (result.found_kind == '0))
    else $error("nonzero found_kind on a rejected transaction");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed or dropped");

endmodule

bind kth_item_count_tree_unit kitc_checker u_kitc_checker (.*);
